@@ sv/d2h_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// d2h_pkg: shared types and constants of the genotype ploidy converter
// Sizes, field codes, request and result records and the sequencer states.
// ----------------------------------------------------------------------------
package d2h_pkg;

   // Sizes
   localparam int MAX_ENTRIES = 64;
   localparam int MAX_ALLELES = 10;
   localparam int VALUE_BITS  = 32;
   localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = 7;
   localparam int ENTRY_BITS  = VALUE_BITS + 1;
   // Headroom for the signed sum of up to 45 heterozygote terms.
   localparam int HET_BITS    = VALUE_BITS + 8;

   localparam logic [CNT_BITS-1:0]   MAX_ENTRIES_CNT = CNT_BITS'(MAX_ENTRIES);
   localparam logic [3:0]            MAX_ALLELES_CNT = 4'(MAX_ALLELES);
   localparam logic [VALUE_BITS-1:0] ONE_FIX = {2'b01, {(VALUE_BITS - 2){1'b0}}};

   // Ploidy codes
   localparam logic [7:0] PLOIDY_ZERO    = 8'd0;
   localparam logic [7:0] PLOIDY_HAPLOID = 8'd1;
   localparam logic [7:0] PLOIDY_DIPLOID = 8'd2;

   // Target ploidy codes (signed field)
   localparam logic signed [2:0] TGT_FORCE_MISSING = -3'sd1;
   localparam logic signed [2:0] TGT_ZERO          = 3'sd0;
   localparam logic signed [2:0] TGT_DIPLOID       = 3'sd2;

   // Order type codes
   localparam logic [2:0] ORD_UNORD_GENO  = 3'd0;
   localparam logic [2:0] ORD_PHASED_HAP  = 3'd1;
   localparam logic [2:0] ORD_ORDERED_HAP = 3'd2;
   localparam logic [2:0] ORD_UNORD_HAP   = 3'd3;

   // Value type codes
   localparam logic [1:0] VT_PROB   = 2'd0;
   localparam logic [1:0] VT_ALLELE = 2'd1;

   // One stored entry: missing flag and value.
   typedef struct packed {
      logic                  miss;
      logic [VALUE_BITS-1:0] val;
   } entry_type;

   // One request as it enters the block.
   typedef struct packed {
      logic signed [2:0]     target_ploidy;
      logic [7:0]            source_ploidy;
      logic [2:0]            order_code;
      logic [1:0]            value_code;
      logic [CNT_BITS-1:0]   entry_count;
      logic [3:0]            allele_count;
      logic [5:0]            entry_index;
      logic                  is_missing;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic [7:0]            ploidy;
      logic [CNT_BITS-1:0]   count;
      logic [2:0]            order_code;
      logic [1:0]            value_code;
      logic                  has_value;
      logic                  missing;
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  error;
   } rsp_type;

   // Commands to the shared accumulate and compare unit.
   typedef struct packed {
      logic clear;
      logic het_en;
      logic first_en;
      logic cmp_en;
   } alu_ctl_type;

   // Status back from the shared unit.
   typedef struct packed {
      logic                  het_positive;
      logic                  call_miss;
      logic [VALUE_BITS-1:0] first_val;
   } alu_status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_CALL_SCAN,
      ST_CALL_DRAIN,
      ST_CALL_OUT,
      ST_HET_SCAN,
      ST_HET_DRAIN,
      ST_HOM_READ,
      ST_HOM_OUT
   } state_type;

endpackage
`default_nettype wire

@@ sv/d2h_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// d2h_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module d2h_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/d2h_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// d2h_alu: shared accumulate and compare unit
// Sums heterozygote terms for the probability run and checks that all
// entries of a call run agree with the first one.
// ----------------------------------------------------------------------------
module d2h_alu import d2h_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire alu_ctl_type    alu_ctl,
   input  wire entry_type      alu_data,
   output alu_status_type      alu_status
);

   logic signed [HET_BITS-1:0] het_ff, het_in;
   logic signed [HET_BITS-1:0] term;
   entry_type                  first_ff, first_in;
   logic                       call_miss_ff, call_miss_in;

   // A missing entry counts as minus one, a present one as its value.
   always_comb begin
      if (alu_data.miss) begin
         term = -$signed(HET_BITS'(ONE_FIX));
      end else begin
         term = $signed(HET_BITS'(alu_data.val));
      end
   end

   // Next values of the accumulator and the call comparison.
   always_comb begin
      het_in       = het_ff;
      first_in     = first_ff;
      call_miss_in = call_miss_ff;
      if (alu_ctl.clear) begin
         het_in = '0;
      end else if (alu_ctl.het_en) begin
         het_in = het_ff + term;
      end
      if (alu_ctl.first_en) begin
         first_in     = alu_data;
         call_miss_in = alu_data.miss;
      end else if (alu_ctl.cmp_en) begin
         call_miss_in = call_miss_ff || alu_data.miss || (alu_data.val != first_ff.val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         het_ff       <= '0;
         call_miss_ff <= 1'b0;
      end else begin
         het_ff       <= het_in;
         call_miss_ff <= call_miss_in;
      end
      first_ff <= first_in;
   end

   assign alu_status.het_positive = !het_ff[HET_BITS-1] && (het_ff != '0);
   assign alu_status.call_miss    = call_miss_ff;
   assign alu_status.first_val    = first_ff.val;

endmodule
`default_nettype wire

@@ sv/d2h_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// d2h_ctrl: request decoder, run sequencer and result register
// Passes simple requests through, buffers converted entries in the entry RAM
// and, at the last entry, emits the converted run, from the RAM where needed.
// ----------------------------------------------------------------------------
module d2h_ctrl import d2h_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp,
   output logic                      ram_wr_en,
   output logic [ADDR_BITS-1:0]      ram_wr_addr,
   output entry_type                 ram_wr_data,
   output logic                      ram_rd_en,
   output logic [ADDR_BITS-1:0]      ram_rd_addr,
   input  wire entry_type            ram_rd_data,
   output alu_ctl_type               alu_ctl,
   output entry_type                 alu_data,
   input  wire alu_status_type       alu_status
);

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0] n_ff, n_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] hom_pos_ff, hom_pos_in;
   logic [7:0]          fill_ploidy_ff, fill_ploidy_in;
   logic [3:0]          alleles_ff, alleles_in;
   logic [3:0]          allele_ff, allele_in;
   logic [3:0]          step_ff, step_in;

   logic tag_valid_ff, tag_valid_in;
   logic tag_call_ff, tag_call_in;
   logic tag_hom_ff, tag_hom_in;
   logic tag_first_ff, tag_first_in;
   logic tag_range_ff, tag_range_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                src_ok;
   logic                want_conv;
   logic                is_last;
   logic                tgt_neg1;
   logic                tgt_zero;
   logic                call_order;
   logic [3:0]          alleles_sat;
   logic [CNT_BITS-1:0] idx_inc;
   logic                at_hom;
   logic                last_allele;
   logic                fill_last;
   logic                alu_clear;
   entry_type           fetched;

   function automatic rsp_type make_rsp(input logic [7:0]            ploidy,
                                        input logic [CNT_BITS-1:0]   count,
                                        input logic [2:0]            ord,
                                        input logic [1:0]            vt,
                                        input logic                  has,
                                        input logic                  miss,
                                        input logic [VALUE_BITS-1:0] val,
                                        input logic                  last,
                                        input logic                  err);
      rsp_type r;
      r.ploidy     = ploidy;
      r.count      = count;
      r.order_code = ord;
      r.value_code = vt;
      r.has_value  = has;
      r.missing    = miss;
      r.value      = (miss || !has) ? '0 : val;
      r.last       = last;
      r.error      = err;
      return r;
   endfunction

   // Request decode and common conditions.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE) && out_free;
   assign accept      = req_valid && req_ready;
   assign src_ok      = (req.source_ploidy == PLOIDY_DIPLOID);
   assign want_conv   = (req.target_ploidy < TGT_DIPLOID) &&
                        (((req.order_code == ORD_UNORD_GENO ||
                           req.order_code == ORD_PHASED_HAP) && req.value_code == VT_PROB) ||
                         ((req.order_code == ORD_ORDERED_HAP ||
                           req.order_code == ORD_UNORD_HAP) && req.value_code == VT_ALLELE));
   assign is_last     = (({1'b0, req.entry_index} + CNT_BITS'(1)) == req.entry_count);
   assign tgt_neg1    = (req.target_ploidy == TGT_FORCE_MISSING);
   assign tgt_zero    = (req.target_ploidy == TGT_ZERO);
   assign call_order  = (req.order_code == ORD_ORDERED_HAP) ||
                        (req.order_code == ORD_UNORD_HAP);
   assign alleles_sat = (req.allele_count > MAX_ALLELES_CNT) ? MAX_ALLELES_CNT
                                                             : req.allele_count;
   assign idx_inc     = idx_ff + CNT_BITS'(1);
   assign at_hom      = (idx_ff == hom_pos_ff);
   assign last_allele = ((allele_ff + 4'd1) == alleles_ff);
   assign fill_last   = (idx_inc == count_ff);

   // An entry outside the run or the store reads as present with value zero.
   assign fetched     = tag_range_ff ? ram_rd_data : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && src_ok && want_conv && is_last) begin
               if (tgt_neg1) begin
                  state_in = ST_FILL;
               end else if (tgt_zero) begin
                  state_in = ST_IDLE;
               end else if (call_order) begin
                  state_in = ST_CALL_SCAN;
               end else if (alleles_sat == 4'd0) begin
                  state_in = ST_IDLE;
               end else if (req.order_code == ORD_PHASED_HAP) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_HET_SCAN;
               end
            end
         end
         ST_FILL: begin
            if (out_free && fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CALL_SCAN: begin
            if (idx_inc == n_ff) begin
               state_in = ST_CALL_DRAIN;
            end
         end
         ST_CALL_DRAIN: begin
            state_in = ST_CALL_OUT;
         end
         ST_CALL_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_HET_SCAN: begin
            if (at_hom && last_allele) begin
               state_in = ST_HET_DRAIN;
            end
         end
         ST_HET_DRAIN: begin
            state_in = ST_HOM_READ;
         end
         ST_HOM_READ: begin
            state_in = ST_HOM_OUT;
         end
         ST_HOM_OUT: begin
            if (out_free) begin
               state_in = last_allele ? ST_IDLE : ST_HOM_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls, counters and result loading.
   always_comb begin
      n_in           = n_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      hom_pos_in     = hom_pos_ff;
      fill_ploidy_in = fill_ploidy_ff;
      alleles_in     = alleles_ff;
      allele_in      = allele_ff;
      step_in        = step_ff;
      tag_valid_in   = 1'b0;
      tag_call_in    = 1'b0;
      tag_hom_in     = 1'b0;
      tag_first_in   = 1'b0;
      tag_range_in   = tag_range_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = req.entry_index[ADDR_BITS-1:0];
      ram_wr_data.miss = req.is_missing;
      ram_wr_data.val  = req.is_missing ? '0 : req.value;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff[ADDR_BITS-1:0];
      alu_clear      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!src_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(req.source_ploidy, '0, ORD_UNORD_GENO, VT_PROB,
                                    1'b0, 1'b0, '0, 1'b1, 1'b1);
               end else if (!want_conv) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(PLOIDY_DIPLOID, req.entry_count, req.order_code,
                                    req.value_code, 1'b1, req.is_missing, req.value,
                                    is_last, 1'b0);
               end else begin
                  // Buffer the entry and prime the run counters.
                  ram_wr_en  = ({1'b0, req.entry_index} < MAX_ENTRIES_CNT);
                  n_in       = req.entry_count;
                  alleles_in = alleles_sat;
                  idx_in     = '0;
                  allele_in  = 4'd0;
                  hom_pos_in = '0;
                  step_in    = 4'd2;
                  if (is_last) begin
                     if (tgt_neg1) begin
                        fill_ploidy_in = PLOIDY_DIPLOID;
                        count_in       = req.entry_count;
                     end else if (tgt_zero && !call_order) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(PLOIDY_HAPLOID, CNT_BITS'(1), ORD_UNORD_GENO,
                                          VT_PROB, 1'b1, 1'b0, ONE_FIX, 1'b1, 1'b0);
                     end else if (tgt_zero) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(PLOIDY_ZERO, '0, ORD_ORDERED_HAP, VT_ALLELE,
                                          1'b0, 1'b0, '0, 1'b1, 1'b0);
                     end else if (call_order) begin
                        idx_in = '0;
                     end else if (alleles_sat == 4'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(PLOIDY_HAPLOID, '0, ORD_UNORD_GENO, VT_PROB,
                                          1'b0, 1'b0, '0, 1'b1, 1'b0);
                     end else if (req.order_code == ORD_PHASED_HAP) begin
                        fill_ploidy_in = PLOIDY_HAPLOID;
                        count_in       = CNT_BITS'(alleles_sat);
                     end else begin
                        alu_clear = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FILL: begin
            // Every result of the run is missing.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(fill_ploidy_ff, count_ff, ORD_UNORD_GENO, VT_PROB,
                                 1'b1, 1'b1, '0, fill_last, 1'b0);
               idx_in = idx_inc;
            end
         end
         ST_CALL_SCAN: begin
            // Read every entry of the run, one a cycle.
            ram_rd_en    = 1'b1;
            tag_valid_in = 1'b1;
            tag_call_in  = 1'b1;
            tag_first_in = (idx_ff == '0);
            tag_range_in = (idx_ff < MAX_ENTRIES_CNT);
            idx_in       = idx_inc;
         end
         ST_CALL_DRAIN: begin
         end
         ST_CALL_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(PLOIDY_HAPLOID, CNT_BITS'(1), ORD_ORDERED_HAP, VT_ALLELE,
                                 1'b1, alu_status.call_miss, alu_status.first_val,
                                 1'b1, 1'b0);
            end
         end
         ST_HET_SCAN: begin
            // Walk up to the last homozygote, summing the entries between.
            ram_rd_en    = 1'b1;
            tag_valid_in = 1'b1;
            tag_hom_in   = at_hom;
            tag_range_in = (idx_ff < n_ff) && (idx_ff < MAX_ENTRIES_CNT);
            idx_in       = idx_inc;
            if (at_hom) begin
               hom_pos_in = hom_pos_ff + CNT_BITS'(step_ff);
               step_in    = step_ff + 4'd1;
               allele_in  = allele_ff + 4'd1;
            end
         end
         ST_HET_DRAIN: begin
            allele_in  = 4'd0;
            hom_pos_in = '0;
            step_in    = 4'd2;
         end
         ST_HOM_READ: begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = hom_pos_ff[ADDR_BITS-1:0];
            tag_range_in = (hom_pos_ff < n_ff) && (hom_pos_ff < MAX_ENTRIES_CNT);
         end
         ST_HOM_OUT: begin
            // Emit the homozygote, missing if it is missing or the het sum is positive.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(PLOIDY_HAPLOID, CNT_BITS'(alleles_ff), ORD_UNORD_GENO,
                                 VT_PROB, 1'b1, alu_status.het_positive || fetched.miss,
                                 fetched.val, last_allele, 1'b0);
               hom_pos_in = hom_pos_ff + CNT_BITS'(step_ff);
               step_in    = step_ff + 4'd1;
               allele_in  = allele_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Read data from the previous cycle drives the shared unit.
   assign alu_data         = fetched;
   assign alu_ctl.clear    = alu_clear;
   assign alu_ctl.het_en   = tag_valid_ff && !tag_call_ff && !tag_hom_ff;
   assign alu_ctl.first_en = tag_valid_ff && tag_call_ff && tag_first_ff;
   assign alu_ctl.cmp_en   = tag_valid_ff && tag_call_ff && !tag_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tag_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_valid_ff <= tag_valid_in;
      end
      n_ff           <= n_in;
      count_ff       <= count_in;
      idx_ff         <= idx_in;
      hom_pos_ff     <= hom_pos_in;
      fill_ploidy_ff <= fill_ploidy_in;
      alleles_ff     <= alleles_in;
      allele_ff      <= allele_in;
      step_ff        <= step_in;
      tag_call_ff    <= tag_call_in;
      tag_hom_ff     <= tag_hom_in;
      tag_first_ff   <= tag_first_in;
      tag_range_ff   <= tag_range_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Read tags only follow a scanning state.
   assert property (@(posedge clock) disable iff (reset)
      tag_valid_ff |-> $past(state_ff == ST_CALL_SCAN || state_ff == ST_HET_SCAN))
      else $error("read tag without a scan");

   // The homozygote pointer never falls behind the scan index.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HET_SCAN |-> hom_pos_ff >= idx_ff)
      else $error("homozygote pointer behind scan index");

   // Emission counters stay inside the run.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOM_OUT |-> allele_ff < alleles_ff)
      else $error("allele counter beyond run");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> idx_ff < count_ff)
      else $error("fill counter beyond run");

endmodule
`default_nettype wire

@@ sv/diploid_to_haploid_genotype_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// diploid_to_haploid_genotype_converter: per-sample ploidy conversion
// Passes diploid entries through or buffers them and emits a haploid,
// zero-ploid or all-missing run at the last entry of the sample.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Carries
//   req_*     in          req_valid/req_ready    one genotype entry
//   rsp_*     out         rsp_valid/rsp_ready    one result of a run
//
// Pass-through, error and buffered entries are taken one after another while
// the result register is free. At the last entry of a converted sample a
// forced-missing or phased run emits one result a cycle while the result
// register is free; a call run scans its n entries and emits one result; a
// probability run scans (A-1)(A+2)/2 + 1 entries, then emits its A results,
// each read first from the RAM read port. Requests wait while a run is emitted.
// Reset clears the sequencer and the result register; the entry RAM needs
// no clearing. A stalled result holds in the result register.
// ----------------------------------------------------------------------------
module diploid_to_haploid_genotype_converter import d2h_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [2:0]       req_target_ploidy,
   input  wire logic [7:0]              req_source_ploidy,
   input  wire logic [2:0]              req_order_type,
   input  wire logic [1:0]              req_value_type,
   input  wire logic [CNT_BITS-1:0]     req_entry_count,
   input  wire logic [3:0]              req_allele_count,
   input  wire logic [5:0]              req_entry_index,
   input  wire logic                    req_is_missing,
   input  wire logic [VALUE_BITS-1:0]   req_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_ploidy,
   output logic [CNT_BITS-1:0]          rsp_out_count,
   output logic [2:0]                   rsp_out_order_type,
   output logic [1:0]                   rsp_out_value_type,
   output logic                         rsp_has_value,
   output logic                         rsp_out_missing,
   output logic [VALUE_BITS-1:0]        rsp_out_value,
   output logic                         rsp_last,
   output logic                         rsp_error
);

   req_type             req;
   rsp_type             rsp;
   logic                ram_wr_en;
   logic [ADDR_BITS-1:0] ram_wr_addr;
   entry_type           ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_BITS-1:0] ram_rd_addr;
   entry_type           ram_rd_data;
   alu_ctl_type         alu_ctl;
   entry_type           alu_data;
   alu_status_type      alu_status;

   // Gather the request fields.
   assign req.target_ploidy = req_target_ploidy;
   assign req.source_ploidy = req_source_ploidy;
   assign req.order_code    = req_order_type;
   assign req.value_code    = req_value_type;
   assign req.entry_count   = req_entry_count;
   assign req.allele_count  = req_allele_count;
   assign req.entry_index   = req_entry_index;
   assign req.is_missing    = req_is_missing;
   assign req.value         = req_value;

   d2h_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .alu_ctl     (alu_ctl),
      .alu_data    (alu_data),
      .alu_status  (alu_status)
   );

   d2h_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   d2h_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_ctl    (alu_ctl),
      .alu_data   (alu_data),
      .alu_status (alu_status)
   );

   // Spread the result record over the ports.
   assign rsp_out_ploidy     = rsp.ploidy;
   assign rsp_out_count      = rsp.count;
   assign rsp_out_order_type = rsp.order_code;
   assign rsp_out_value_type = rsp.value_code;
   assign rsp_has_value      = rsp.has_value;
   assign rsp_out_missing    = rsp.missing;
   assign rsp_out_value      = rsp.value;
   assign rsp_last           = rsp.last;
   assign rsp_error          = rsp.error;

endmodule
`default_nettype wire

@@ sim/diploid_to_haploid_genotype_converter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diploid_to_haploid_genotype_converter_checker: result predictor and scoreboard
// Watches both channels of the ploidy converter. It keeps its own copy of the
// entry store, works out the results that each accepted request causes and
// compares every accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module diploid_to_haploid_genotype_converter_checker import d2h_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  req_type   request,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  rsp_type   response,
   output int        mismatches,
   output int        outstanding
);

   // Shadow of the sample buffer and the queue of results still due.
   entry_type sample_store [MAX_ENTRIES];
   rsp_type   due_genotypes [$];
   int        fail_count = 0;

   // Builds one result; the value is forced to zero when it carries nothing.
   function automatic rsp_type genotype_result(input logic [7:0] ploidy,
                                               input logic [CNT_BITS-1:0] count,
                                               input logic [2:0] ord,
                                               input logic [1:0] vt,
                                               input logic has,
                                               input logic miss,
                                               input logic [VALUE_BITS-1:0] val,
                                               input logic last,
                                               input logic err);
      rsp_type res;
      res.ploidy     = ploidy;
      res.count      = count;
      res.order_code = ord;
      res.value_code = vt;
      res.has_value  = has;
      res.missing    = miss;
      res.value      = (miss || !has) ? '0 : val;
      res.last       = last;
      res.error      = err;
      return res;
   endfunction

   // Entries past the run or past the buffer read as present with value zero.
   function automatic entry_type stored_entry(input int idx, input int n);
      if (idx >= n || idx >= MAX_ENTRIES) begin
         return '0;
      end
      return sample_store[idx];
   endfunction

   // Works out the results of one accepted request and queues them.
   task automatic predict_genotype_results(input req_type req);
      int        target;
      int        n;
      int        idx;
      int        alleles;
      int        h;
      bit        convert;
      bit        calls;
      bit        is_last;
      bit        call_miss;
      bit        all_missing;
      longint    het_sum;
      entry_type first;
      entry_type e;
      entry_type hom [MAX_ALLELES];

      target  = int'($signed(req.target_ploidy));
      n       = int'(req.entry_count);
      idx     = int'(req.entry_index);
      is_last = (idx + 1 == n);

      // A source that is not diploid gives a lone error result.
      if (req.source_ploidy != PLOIDY_DIPLOID) begin
         due_genotypes.push_back(genotype_result(req.source_ploidy, '0, '0, '0,
                                                 1'b0, 1'b0, '0, 1'b1, 1'b1));
         return;
      end

      calls   = (req.order_code == ORD_ORDERED_HAP || req.order_code == ORD_UNORD_HAP);
      convert = target < int'(TGT_DIPLOID) &&
                (((req.order_code == ORD_UNORD_GENO || req.order_code == ORD_PHASED_HAP)
                  && req.value_code == VT_PROB) ||
                 (calls && req.value_code == VT_ALLELE));

      // Anything that needs no conversion is echoed straight back.
      if (!convert) begin
         due_genotypes.push_back(genotype_result(PLOIDY_DIPLOID, req.entry_count,
                                                 req.order_code, req.value_code, 1'b1,
                                                 req.is_missing, req.value, is_last,
                                                 1'b0));
         return;
      end

      sample_store[idx].miss = req.is_missing;
      sample_store[idx].val  = req.is_missing ? '0 : req.value;
      if (!is_last) begin
         return;
      end

      alleles = (req.allele_count > MAX_ALLELES_CNT) ? MAX_ALLELES : int'(req.allele_count);

      if (target == int'(TGT_FORCE_MISSING)) begin
         // Forced missing: the whole diploid run comes out missing.
         for (int i = 0; i < n; i++) begin
            due_genotypes.push_back(genotype_result(PLOIDY_DIPLOID, CNT_BITS'(n),
                                                    ORD_UNORD_GENO, VT_PROB, 1'b1, 1'b1,
                                                    '0, i + 1 == n, 1'b0));
         end
      end else if (target == int'(TGT_ZERO) && !calls) begin
         due_genotypes.push_back(genotype_result(PLOIDY_HAPLOID, CNT_BITS'(1),
                                                 ORD_UNORD_GENO, VT_PROB, 1'b1, 1'b0,
                                                 ONE_FIX, 1'b1, 1'b0));
      end else if (target == int'(TGT_ZERO)) begin
         due_genotypes.push_back(genotype_result(PLOIDY_ZERO, '0, ORD_ORDERED_HAP,
                                                 VT_ALLELE, 1'b0, 1'b0, '0, 1'b1, 1'b0));
      end else if (calls) begin
         // Haploid call: only an unbroken run of one allele survives.
         first     = stored_entry(0, n);
         call_miss = first.miss;
         for (int i = 1; i < n; i++) begin
            e = stored_entry(i, n);
            if (e.miss || e.val != first.val) begin
               call_miss = 1'b1;
            end
         end
         due_genotypes.push_back(genotype_result(PLOIDY_HAPLOID, CNT_BITS'(1),
                                                 ORD_ORDERED_HAP, VT_ALLELE, 1'b1,
                                                 call_miss, first.val, 1'b1, 1'b0));
      end else if (alleles == 0) begin
         due_genotypes.push_back(genotype_result(PLOIDY_HAPLOID, '0, ORD_UNORD_GENO,
                                                 VT_PROB, 1'b0, 1'b0, '0, 1'b1, 1'b0));
      end else begin
         // Probabilities: gather the homozygotes and sum the heterozygotes
         // lying between them, a missing entry counting as minus one.
         h       = 0;
         het_sum = 0;
         for (int i = 0; i < alleles; i++) begin
            if (i + 1 < alleles) begin
               for (int j = h + 1; j < h + i + 2; j++) begin
                  e = stored_entry(j, n);
                  if (e.miss) begin
                     het_sum = het_sum - longint'(ONE_FIX);
                  end else begin
                     het_sum = het_sum + longint'(e.val);
                  end
               end
            end
            hom[i] = stored_entry(h, n);
            h      = h + i + 2;
         end
         all_missing = (req.order_code == ORD_PHASED_HAP) || (het_sum > 0);
         for (int i = 0; i < alleles; i++) begin
            due_genotypes.push_back(genotype_result(PLOIDY_HAPLOID, CNT_BITS'(alleles),
                                                    ORD_UNORD_GENO, VT_PROB, 1'b1,
                                                    all_missing || hom[i].miss,
                                                    hom[i].val, i + 1 == alleles, 1'b0));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Results are compared before the request of the same edge is predicted,
   // since a result is registered and so always leaves after its request.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         due_genotypes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_genotypes.size() == 0) begin
               $error("result accepted with no result due");
               fail_count++;
            end else begin
               want = due_genotypes.pop_front();
               check_field("out_ploidy", 64'(want.ploidy), 64'(response.ploidy));
               check_field("out_count", 64'(want.count), 64'(response.count));
               check_field("out_order_type", 64'(want.order_code),
                           64'(response.order_code));
               check_field("out_value_type", 64'(want.value_code),
                           64'(response.value_code));
               check_field("has_value", 64'(want.has_value), 64'(response.has_value));
               check_field("out_missing", 64'(want.missing), 64'(response.missing));
               check_field("out_value", 64'(want.value), 64'(response.value));
               check_field("last", 64'(want.last), 64'(response.last));
               check_field("error", 64'(want.error), 64'(response.error));
            end
         end
         if (req_valid && req_ready) begin
            predict_genotype_results(request);
         end
      end
      mismatches  <= fail_count;
      outstanding <= due_genotypes.size();
   end

endmodule

@@ sim/diploid_to_haploid_genotype_converter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diploid_to_haploid_genotype_converter_test: top of the converter testbench
// Drives directed and then random genotype requests, mostly whole samples
// with random content, with random gaps and result stalls on both sides.
// The checker beside the block predicts and compares; this top gives the
// verdict once every result due has arrived.
// ----------------------------------------------------------------------------
module diploid_to_haploid_genotype_converter_test import d2h_pkg::*; ();

   localparam int IDLE_LIMIT      = 4000;
   localparam int HOLD_OFF_AFTER  = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REQUEST_GOAL    = 440;
   localparam int PAUSE_AT        = 260;
   localparam int DRAIN_CYCLES    = 200;

   // Codes outside the converted set
   localparam int ORD_OTHER = 4;
   localparam int VT_OTHER  = 2;

   // How the values of a sample are chosen
   typedef enum int {
      VAL_FULL,
      VAL_SPARSE,
      VAL_EQUAL,
      VAL_SMALL,
      VAL_HOM_ONLY,
      VAL_HET_MISSING
   } value_style_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               request   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_ploidy;
   logic [CNT_BITS-1:0]   rsp_out_count;
   logic [2:0]            rsp_out_order_type;
   logic [1:0]            rsp_out_value_type;
   logic                  rsp_has_value;
   logic                  rsp_out_missing;
   logic [VALUE_BITS-1:0] rsp_out_value;
   logic                  rsp_last;
   logic                  rsp_error;
   rsp_type               response;
   int                    mismatches;
   int                    outstanding;
   int                    requests_sent = 0;
   int                    sender_calm   = 0;
   int                    receiver_calm = 0;
   int                    idle_cycles   = 0;

   diploid_to_haploid_genotype_converter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_ploidy  (request.target_ploidy),
      .req_source_ploidy  (request.source_ploidy),
      .req_order_type     (request.order_code),
      .req_value_type     (request.value_code),
      .req_entry_count    (request.entry_count),
      .req_allele_count   (request.allele_count),
      .req_entry_index    (request.entry_index),
      .req_is_missing     (request.is_missing),
      .req_value          (request.value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_ploidy     (rsp_out_ploidy),
      .rsp_out_count      (rsp_out_count),
      .rsp_out_order_type (rsp_out_order_type),
      .rsp_out_value_type (rsp_out_value_type),
      .rsp_has_value      (rsp_has_value),
      .rsp_out_missing    (rsp_out_missing),
      .rsp_out_value      (rsp_out_value),
      .rsp_last           (rsp_last),
      .rsp_error          (rsp_error)
   );

   assign response = {rsp_out_ploidy, rsp_out_count, rsp_out_order_type,
                      rsp_out_value_type, rsp_has_value, rsp_out_missing,
                      rsp_out_value, rsp_last, rsp_error};

   diploid_to_haploid_genotype_converter_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .request     (request),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .response    (response),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle cycles before the next request or result, with calm stretches.
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic req_type make_request(input int tgt, input int src, input int ord,
                                            input int vt, input int n, input int alleles,
                                            input int idx, input bit miss,
                                            input logic [VALUE_BITS-1:0] val);
      req_type r;
      r.target_ploidy = 3'(tgt);
      r.source_ploidy = 8'(src);
      r.order_code    = 3'(ord);
      r.value_code    = 2'(vt);
      r.entry_count   = CNT_BITS'(n);
      r.allele_count  = 4'(alleles);
      r.entry_index   = 6'(idx);
      r.is_missing    = miss;
      r.value         = val;
      return r;
   endfunction

   // Offers one request from a falling edge and holds it until it is taken.
   task automatic send_request(input req_type r);
      int gap;
      gap = draw_idle(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      request   <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   // Sends entries 0..sent_len-1 of one diploid sample.
   task automatic send_sample(input int tgt, input int ord, input int vt, input int n,
                              input int alleles, input int sent_len,
                              input int miss_chance, input value_style_type style);
      logic [VALUE_BITS-1:0] common;
      logic [VALUE_BITS-1:0] v;
      bit                    m;
      bit                    hom;
      common = $urandom_range(0, 9);
      for (int idx = 0; idx < sent_len; idx++) begin
         hom = 1'b0;
         for (int i = 0; i * (i + 3) / 2 <= idx; i++) begin
            if (i * (i + 3) / 2 == idx) begin
               hom = 1'b1;
            end
         end
         m = miss_chance > 0 && $urandom_range(1, 32) <= miss_chance;
         case (style)
            VAL_FULL:     v = $urandom;
            VAL_SPARSE:   v = ($urandom_range(0, 3) == 0) ? $urandom : '0;
            VAL_EQUAL:    v = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 9) : common;
            VAL_SMALL:    v = $urandom_range(0, 3);
            VAL_HOM_ONLY: v = hom ? $urandom : '0;
            default: begin
               v = $urandom;
               m = m || !hom;
            end
         endcase
         send_request(make_request(tgt, PLOIDY_DIPLOID, ord, vt, n, alleles, idx, m, v));
      end
   endtask

   // A sample that needs conversion, whole or cut short.
   task automatic send_random_sample(input bit broken);
      int              tgt;
      int              ord;
      int              vt;
      int              n;
      int              alleles;
      int              miss_chance;
      bit              calls;
      value_style_type style;
      case ($urandom_range(0, 7))
         0:       tgt = TGT_FORCE_MISSING;
         1:       tgt = TGT_ZERO;
         2:       tgt = -2;
         3:       tgt = -3;
         4:       tgt = -4;
         default: tgt = 1;
      endcase
      calls   = 1'($urandom_range(0, 1));
      ord     = calls ? $urandom_range(ORD_ORDERED_HAP, ORD_UNORD_HAP)
                      : $urandom_range(ORD_UNORD_GENO, ORD_PHASED_HAP);
      vt      = calls ? VT_ALLELE : VT_PROB;
      n       = ($urandom_range(0, 15) == 0) ? $urandom_range(11, MAX_ENTRIES)
                                             : $urandom_range(1, 10);
      alleles = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      case ($urandom_range(0, 2))
         0:       miss_chance = 0;
         1:       miss_chance = 2;
         default: miss_chance = 8;
      endcase
      if (calls) begin
         style = ($urandom_range(0, 2) == 0) ? VAL_SMALL : VAL_EQUAL;
      end else begin
         case ($urandom_range(0, 3))
            0:       style = VAL_FULL;
            1:       style = VAL_SPARSE;
            2:       style = VAL_HOM_ONLY;
            default: style = VAL_HET_MISSING;
         endcase
      end
      if (broken && n > 1) begin
         send_sample(tgt, ord, vt, n, alleles, $urandom_range(1, n - 1), miss_chance, style);
         if ($urandom_range(0, 1) == 0) begin
            send_request(make_request(tgt, $urandom_range(3, 255), ord, vt, n, alleles,
                                      $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                                      $urandom));
         end
      end else begin
         send_sample(tgt, ord, vt, n, alleles, n, miss_chance, style);
      end
   endtask

   // Stops offering until every result due has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // Result side: random stalls, and one long hold-off so the block backs up.
   initial begin
      int  stall;
      int  taken;
      bit  held;
      taken = 0;
      held  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && taken >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            stall = draw_idle(receiver_calm);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("diploid_to_haploid_genotype_converter verification failed");
      $finish;
   end

   // Request side and verdict
   initial begin
      bit paused;
      int pick;
      int n;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: pass-through at the field extremes and error sources.
      send_request(make_request(TGT_DIPLOID, PLOIDY_DIPLOID, ORD_OTHER, VT_OTHER, 1, 10, 0,
                                1'b0, '1));
      send_request(make_request(3, PLOIDY_DIPLOID, ORD_UNORD_GENO, VT_ALLELE, 127, 15, 63,
                                1'b1, '1));
      send_request(make_request(1, PLOIDY_ZERO, ORD_UNORD_GENO, VT_PROB, 1, 2, 0, 1'b0, '1));
      send_request(make_request(-4, 255, ORD_UNORD_HAP, VT_ALLELE, 64, 1, 63, 1'b1, '1));
      // Zero-ploid targets, forced missing and the haploid probability cases.
      send_sample(TGT_ZERO, ORD_UNORD_GENO, VT_PROB, 1, 2, 1, 0, VAL_FULL);
      send_sample(TGT_ZERO, ORD_ORDERED_HAP, VT_ALLELE, 1, 2, 1, 0, VAL_SMALL);
      send_sample(TGT_FORCE_MISSING, ORD_PHASED_HAP, VT_PROB, 2, 2, 2, 0, VAL_FULL);
      send_sample(1, ORD_UNORD_GENO, VT_PROB, 3, 2, 3, 0, VAL_HOM_ONLY);
      send_sample(1, ORD_UNORD_GENO, VT_PROB, 3, 2, 3, 0, VAL_FULL);
      send_sample(1, ORD_UNORD_GENO, VT_PROB, 3, 2, 3, 0, VAL_HET_MISSING);
      send_sample(1, ORD_PHASED_HAP, VT_PROB, 1, 3, 1, 0, VAL_FULL);
      send_sample(1, ORD_UNORD_GENO, VT_PROB, 1, 0, 1, 0, VAL_FULL);
      send_sample(1, ORD_UNORD_GENO, VT_PROB, 1, 15, 1, 0, VAL_FULL);
      send_sample(-2, ORD_UNORD_GENO, VT_PROB, 1, 1, 1, 0, VAL_FULL);
      // Haploid calls: one agreeing run and one that disagrees.
      send_sample(1, ORD_UNORD_HAP, VT_ALLELE, 2, 2, 2, 0, VAL_EQUAL);
      send_sample(1, ORD_ORDERED_HAP, VT_ALLELE, 2, 2, 2, 0, VAL_FULL);
      wait_for_results();

      // A full-width sample first, so every buffer entry holds a known value
      // before random requests may read anywhere in it.
      send_sample(TGT_FORCE_MISSING, ORD_UNORD_GENO, VT_PROB, MAX_ENTRIES, 2, MAX_ENTRIES,
                  4, VAL_FULL);

      // Random: mostly whole samples, the rest pass-through, broken samples
      // and requests with every field random.
      while (requests_sent < REQUEST_GOAL) begin
         if (!paused && requests_sent >= PAUSE_AT) begin
            paused = 1'b1;
            wait_for_results();
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_random_sample(1'b0);
         end else if (pick < 16) begin
            send_random_sample(1'b1);
         end else if (pick < 18) begin
            n = $urandom_range(1, MAX_ENTRIES);
            send_request(make_request($urandom_range(2, 3), PLOIDY_DIPLOID,
                                      $urandom_range(0, 7), $urandom_range(0, 3), n,
                                      $urandom_range(0, 15), $urandom_range(0, n - 1),
                                      1'($urandom_range(0, 1)), $urandom));
         end else begin
            send_request(make_request($urandom_range(0, 7),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                  : PLOIDY_DIPLOID,
                                      $urandom_range(0, 7), $urandom_range(0, 3),
                                      ($urandom_range(0, 7) == 0) ? 0
                                                                  : $urandom_range(1, 127),
                                      $urandom_range(0, 15), $urandom_range(0, 63),
                                      1'($urandom_range(0, 1)), $urandom));
         end
      end

      // Drain, then allow for a late run the block might still emit.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("diploid_to_haploid_genotype_converter verification clean");
      end else begin
         $display("diploid_to_haploid_genotype_converter verification failed");
      end
      $finish;
   end

endmodule
